// ===== design/a2e_pkg.sv =====
// ----------------------------------------------------------------------------
// a2e_pkg: shared types and constants for the ASN.1 time converter
// Widths, field codes, divider operation codes, sequencer states and the
// cumulative month table.
// ----------------------------------------------------------------------------
package a2e_pkg;

    localparam int STORE_DEPTH = 15;
    localparam int COUNT_SAT   = 16;
    localparam int COUNT_W     = 5;
    localparam int IDX_W       = 4;

    localparam int LEN_UTC     = 13;
    localparam int LEN_GEN     = 15;
    localparam int LAST_POS    = 13;

    localparam int CHAR_ZERO   = 48;
    localparam int DIG_W       = 9;
    localparam int YEAR_W      = 19;
    localparam int FIELD_W     = 13;
    localparam int QUO_W       = YEAR_W + 1;
    localparam int DVS_W       = 9;
    localparam int YM_W        = YEAR_W + 1;
    localparam int CSUM_W      = 24;
    localparam int OPA_W       = 28;
    localparam int OPB_W       = 18;
    localparam int ACC_W       = 48;
    localparam int EPOCH_W     = 64;

    localparam int EPOCH_YEAR  = 1970;
    localparam int BASE_YEAR   = EPOCH_YEAR - 1;
    localparam int LEAP_BASE   = -(BASE_YEAR / 4) + (BASE_YEAR / 100) - (BASE_YEAR / 400);
    localparam int UTC_PIVOT   = 50;
    localparam int CENTURY_19  = 1900;
    localparam int CENTURY_20  = 2000;

    localparam int SECS_DAY    = 86400;
    localparam int SECS_HOUR   = 3600;
    localparam int SECS_MIN    = 60;
    localparam int DAYS_YEAR   = 365;

    // field codes: normalized character position divided by two
    localparam logic [2:0] FLD_YEAR0  = 3'd0;
    localparam logic [2:0] FLD_YEAR1  = 3'd1;
    localparam logic [2:0] FLD_MONTH  = 3'd2;
    localparam logic [2:0] FLD_DAY    = 3'd3;
    localparam logic [2:0] FLD_HOUR   = 3'd4;
    localparam logic [2:0] FLD_MINUTE = 3'd5;
    localparam logic [2:0] FLD_SECOND = 3'd6;

    // divider operations, run in this order
    localparam logic [2:0] DOP_YA_4   = 3'd0;
    localparam logic [2:0] DOP_YA_100 = 3'd1;
    localparam logic [2:0] DOP_YA_400 = 3'd2;
    localparam logic [2:0] DOP_Y_100  = 3'd3;
    localparam logic [2:0] DOP_Y_400  = 3'd4;

    typedef enum logic [10:0] {
        ST_COLLECT = 11'b000_0000_0001,
        ST_PARSE   = 11'b000_0000_0010,
        ST_CHECK   = 11'b000_0000_0100,
        ST_DIV_GO  = 11'b000_0000_1000,
        ST_DIV_RUN = 11'b000_0001_0000,
        ST_SUM     = 11'b000_0010_0000,
        ST_DAYS    = 11'b000_0100_0000,
        ST_SEC0    = 11'b000_1000_0000,
        ST_SEC1    = 11'b001_0000_0000,
        ST_SEC2    = 11'b010_0000_0000,
        ST_OUT     = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic                     en;
        logic signed [OPA_W-1:0]  a;
        logic signed [OPB_W-1:0]  b;
        logic signed [ACC_W-1:0]  c;
    } mac_req_t;

    typedef struct packed {
        logic                     start;
        logic signed [YEAR_W-1:0] numer;
        logic [DVS_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [QUO_W-1:0]  quotient;
        logic                     rem_zero;
    } div_rsp_t;

    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ===== design/a2e_char_buf.sv =====
// ----------------------------------------------------------------------------
// a2e_char_buf: character buffer
// Holds up to fifteen bytes of the current string and a saturating count.
// ----------------------------------------------------------------------------
module a2e_char_buf (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic                        wr_last,
    input  logic [7:0]                  wr_data,
    input  logic [a2e_pkg::IDX_W-1:0]   rd_idx,
    output logic [7:0]                  rd_data,
    output logic [a2e_pkg::COUNT_W-1:0] wr_len
);
    import a2e_pkg::*;

    logic [7:0]         store_reg [STORE_DEPTH];
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign wr_len  = (count_reg < COUNT_W'(COUNT_SAT)) ? count_reg + 1'b1 : count_reg;
    assign rd_data = store_reg[rd_idx];

    always_comb begin
        count_next = count_reg;
        if (wr_en) begin
            count_next = wr_last ? '0 : wr_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && count_reg < COUNT_W'(STORE_DEPTH)) begin
            store_reg[count_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(COUNT_SAT))
        else $error("character count above saturation");

endmodule

// ===== design/a2e_mac.sv =====
// ----------------------------------------------------------------------------
// a2e_mac: shared multiply-add unit
// acc <= a * b + c, one operation per enabled cycle.
// ----------------------------------------------------------------------------
module a2e_mac (
    input  logic                              aclk,
    input  a2e_pkg::mac_req_t                 req,
    output logic signed [a2e_pkg::ACC_W-1:0]  acc
);
    import a2e_pkg::*;

    logic signed [OPA_W-1:0]       a_s;
    logic signed [OPB_W-1:0]       b_s;
    logic signed [ACC_W-1:0]       c_s;
    logic signed [OPA_W+OPB_W-1:0] prod;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [ACC_W-1:0]       acc_next;

    assign a_s      = req.a;
    assign b_s      = req.b;
    assign c_s      = req.c;
    assign prod     = a_s * b_s;
    assign acc_next = ACC_W'(prod) + c_s;
    assign acc      = acc_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== design/a2e_divider.sv =====
// ----------------------------------------------------------------------------
// a2e_divider: constant divisor unit
// Signed quotient by 4, 100 or 400 on the magnitude, by a shift or by a
// reciprocal multiplication, with a zero-remainder flag. The quotient
// truncates toward zero. Start runs through v1_reg and v2_reg into done_reg.
// ----------------------------------------------------------------------------
module a2e_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  a2e_pkg::div_req_t req,
    output a2e_pkg::div_rsp_t rsp
);
    import a2e_pkg::*;

    localparam int MAG_W  = YEAR_W;
    localparam int RCP_SH = 25;
    localparam int RCP_W  = 19;
    localparam int PROD_W = MAG_W + RCP_W;
    // ceil(2^25 / 100), exact for magnitudes below 2^18
    localparam logic [RCP_W-1:0] RCP_100 = RCP_W'(335545);

    logic              v1_reg;
    logic              v2_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic              rem_zero_reg;

    logic [MAG_W-1:0]  numer_bits;
    logic [MAG_W-1:0]  numer_mag;
    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  quo_calc;
    logic [MAG_W-1:0]  q_x4;
    logic [MAG_W-1:0]  q_x100;
    logic [MAG_W-1:0]  back;
    logic [QUO_W-1:0]  q_ext;

    assign numer_bits = req.numer;
    assign numer_mag  = numer_bits[MAG_W-1] ? (~numer_bits + 1'b1) : numer_bits;
    assign prod       = PROD_W'(mag_reg) * PROD_W'(RCP_100);
    assign q_x4       = {quo_reg[MAG_W-3:0], 2'b00};
    assign q_x100     = {quo_reg[MAG_W-7:0], 6'd0} + {quo_reg[MAG_W-6:0], 5'd0} + q_x4;
    assign q_ext      = {1'b0, quo_reg};

    always_comb begin
        case (dvs_reg)
            DVS_W'(100): quo_calc = MAG_W'(prod[PROD_W-1:RCP_SH]);
            DVS_W'(400): quo_calc = MAG_W'(prod[PROD_W-1:RCP_SH+2]);
            default:     quo_calc = {2'b00, mag_reg[MAG_W-1:2]};
        endcase
    end

    always_comb begin
        case (dvs_reg)
            DVS_W'(100): back = q_x100;
            DVS_W'(400): back = {q_x100[MAG_W-3:0], 2'b00};
            default:     back = q_x4;
        endcase
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~q_ext + 1'b1) : q_ext;
    assign rsp.rem_zero = rem_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            v1_reg   <= req.start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            neg_reg <= numer_bits[MAG_W-1];
            mag_reg <= numer_mag;
            dvs_reg <= req.divisor;
        end
        if (v1_reg) begin
            quo_reg <= quo_calc;
        end
        if (v2_reg) begin
            rem_zero_reg <= (back == mag_reg);
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !(v1_reg || v2_reg || done_reg))
        else $error("divider started while busy");

endmodule

// ===== design/asn1_time_to_epoch_seconds.sv =====
// ----------------------------------------------------------------------------
// asn1_time_to_epoch_seconds: ASN.1 UTCTime / GeneralizedTime to epoch seconds
// Buffers the characters of a time string and converts it on the last byte.
// ----------------------------------------------------------------------------
// Bytes of a string are taken one per cycle. After the byte marked last the
// input stalls while a small sequencer walks the digits through a shared
// multiply-add unit and runs five passes through a constant divisor unit for
// the leap-year terms. It steps through the digits of the string, one range
// check, five divider passes, the day count and seconds chain, and a load of
// the output register. A bad month or day is answered right after the range
// check, and a string of the wrong length goes straight to the output load.
// The load waits while an earlier result is still held; otherwise a
// result waits in the output register while the next string's bytes are
// already taken.
module asn1_time_to_epoch_seconds (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // [63:0] epoch_seconds
    output logic        m_tuser     // [0] malformed
);
    import a2e_pkg::*;

    localparam logic signed [FIELD_W-1:0] F_ONE      = FIELD_W'(1);
    localparam logic signed [FIELD_W-1:0] F_TWO      = FIELD_W'(2);
    localparam logic signed [FIELD_W-1:0] F_TWELVE   = FIELD_W'(12);
    localparam logic signed [FIELD_W-1:0] F_DAYS_MAX = FIELD_W'(31);
    localparam logic signed [YEAR_W-1:0]  Y_PIVOT    = YEAR_W'(UTC_PIVOT);
    localparam logic signed [YEAR_W-1:0]  Y_C19      = YEAR_W'(CENTURY_19);
    localparam logic signed [YEAR_W-1:0]  Y_C20      = YEAR_W'(CENTURY_20);
    localparam logic signed [OPB_W-1:0]   MUL_TEN    = OPB_W'(10);
    localparam logic signed [OPB_W-1:0]   MUL_YEAR   = OPB_W'(DAYS_YEAR);
    localparam logic signed [OPB_W-1:0]   MUL_DAY    = OPB_W'(SECS_DAY);
    localparam logic signed [OPB_W-1:0]   MUL_HOUR   = OPB_W'(SECS_HOUR);
    localparam logic signed [OPB_W-1:0]   MUL_MIN    = OPB_W'(SECS_MIN);

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      len15_reg, len15_next;
    logic                      bad_reg, bad_next;
    logic                      cap_valid_reg, cap_valid_next;
    logic [2:0]                cap_field_reg, cap_field_next;
    logic [2:0]                op_reg, op_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [EPOCH_W-1:0]        m_tdata_reg;
    logic                      m_tuser_reg;

    logic signed [YEAR_W-1:0]  year_reg;
    logic signed [FIELD_W-1:0] month_reg;
    logic signed [FIELD_W-1:0] day_reg;
    logic signed [FIELD_W-1:0] hour_reg;
    logic signed [FIELD_W-1:0] minute_reg;
    logic signed [FIELD_W-1:0] second_reg;
    logic signed [QUO_W-1:0]   q4_reg;
    logic signed [QUO_W-1:0]   q100_reg;
    logic signed [QUO_W-1:0]   q400_reg;
    logic                      z100_reg;
    logic                      z400_reg;
    logic signed [YM_W-1:0]    ym_reg;
    logic signed [CSUM_W-1:0]  csum_reg;

    logic                      s_accept;
    logic                      out_load;
    logic [7:0]                rd_data;
    logic [COUNT_W-1:0]        wr_len;
    logic [IDX_W-1:0]          pos;
    logic                      field_start;
    logic                      field_end;
    logic signed [DIG_W-1:0]   digit;
    logic                      date_bad;
    logic                      leap;
    logic signed [YEAR_W-1:0]  year_adj;
    logic [8:0]                ms_days;
    logic signed [CSUM_W-1:0]  csum_next;
    mac_req_t                  mac_req;
    logic signed [ACC_W-1:0]   mac_acc;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    assign s_tready = (state_reg == ST_COLLECT);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    a2e_char_buf u_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (s_accept),
        .wr_last (s_tlast),
        .wr_data (s_tdata),
        .rd_idx  (idx_reg),
        .rd_data (rd_data),
        .wr_len  (wr_len)
    );

    a2e_mac u_mac (
        .aclk (aclk),
        .req  (mac_req),
        .acc  (mac_acc)
    );

    a2e_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // UTCTime digits sit two places later in the GeneralizedTime layout
    assign pos         = len15_reg ? idx_reg : idx_reg + IDX_W'(2);
    assign field_start = (idx_reg == '0) || (!pos[0] && pos >= IDX_W'(4));
    assign field_end   = pos[0] && pos >= IDX_W'(3);
    assign digit       = $signed({1'b0, rd_data}) - DIG_W'(CHAR_ZERO);

    assign date_bad = (month_reg < F_ONE) || (month_reg > F_TWELVE)
                   || (day_reg < F_ONE) || (day_reg > F_DAYS_MAX);
    assign leap     = ((year_reg[1:0] == 2'b00) && !z100_reg) || z400_reg;
    assign year_adj = (year_reg >= Y_PIVOT) ? Y_C19 : Y_C20;
    assign ms_days  = month_start(month_reg[3:0]);

    assign csum_next = CSUM_W'(q4_reg) - CSUM_W'(q100_reg) + CSUM_W'(q400_reg)
                     + CSUM_W'(LEAP_BASE) + CSUM_W'($signed({1'b0, ms_days}))
                     + CSUM_W'(day_reg) - CSUM_W'(1)
                     + CSUM_W'($signed({1'b0, (month_reg > F_TWO) && leap}));

    always_comb begin
        mac_req.en = 1'b1;
        mac_req.a  = '0;
        mac_req.b  = '0;
        mac_req.c  = '0;
        case (state_reg)
            ST_PARSE: begin
                mac_req.a = field_start ? '0 : $signed(mac_acc[OPA_W-1:0]);
                mac_req.b = MUL_TEN;
                mac_req.c = ACC_W'(digit);
            end
            ST_DAYS: begin
                mac_req.a = OPA_W'(ym_reg);
                mac_req.b = MUL_YEAR;
                mac_req.c = ACC_W'(csum_reg);
            end
            ST_SEC0: begin
                mac_req.a = $signed(mac_acc[OPA_W-1:0]);
                mac_req.b = MUL_DAY;
                mac_req.c = ACC_W'(second_reg);
            end
            ST_SEC1: begin
                mac_req.a = OPA_W'(hour_reg);
                mac_req.b = MUL_HOUR;
                mac_req.c = mac_acc;
            end
            ST_SEC2: begin
                mac_req.a = OPA_W'(minute_reg);
                mac_req.b = MUL_MIN;
                mac_req.c = mac_acc;
            end
            default: begin
                mac_req.en = 1'b0;
            end
        endcase
    end

    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO);
        div_req.numer = (op_reg == DOP_Y_100 || op_reg == DOP_Y_400)
                      ? year_reg : year_reg - YEAR_W'(1);
        case (op_reg)
            DOP_YA_4:               div_req.divisor = DVS_W'(4);
            DOP_YA_100, DOP_Y_100:  div_req.divisor = DVS_W'(100);
            DOP_YA_400, DOP_Y_400:  div_req.divisor = DVS_W'(400);
            default:                div_req.divisor = DVS_W'(4);
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        len15_next     = len15_reg;
        bad_next       = bad_reg;
        cap_valid_next = 1'b0;
        cap_field_next = cap_field_reg;
        op_next        = op_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_accept && s_tlast) begin
                    idx_next   = '0;
                    len15_next = (wr_len == COUNT_W'(LEN_GEN));
                    if (wr_len == COUNT_W'(LEN_UTC) || wr_len == COUNT_W'(LEN_GEN)) begin
                        bad_next   = 1'b0;
                        state_next = ST_PARSE;
                    end else begin
                        bad_next   = 1'b1;
                        state_next = ST_OUT;
                    end
                end
            end
            ST_PARSE: begin
                cap_valid_next = field_end;
                cap_field_next = pos[3:1];
                idx_next       = idx_reg + 1'b1;
                if (pos == IDX_W'(LAST_POS)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (date_bad) begin
                    bad_next   = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    op_next    = DOP_YA_4;
                    state_next = ST_DIV_GO;
                end
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (div_rsp.done) begin
                    if (op_reg == DOP_Y_400) begin
                        state_next = ST_SUM;
                    end else begin
                        op_next    = op_reg + 1'b1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_SUM:  state_next = ST_DAYS;
            ST_DAYS: state_next = ST_SEC0;
            ST_SEC0: state_next = ST_SEC1;
            ST_SEC1: state_next = ST_SEC2;
            ST_SEC2: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_COLLECT;
            idx_reg       <= '0;
            len15_reg     <= 1'b0;
            bad_reg       <= 1'b0;
            cap_valid_reg <= 1'b0;
            cap_field_reg <= FLD_YEAR0;
            op_reg        <= DOP_YA_4;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len15_reg     <= len15_next;
            bad_reg       <= bad_next;
            cap_valid_reg <= cap_valid_next;
            cap_field_reg <= cap_field_next;
            op_reg        <= op_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cap_valid_reg) begin
            case (cap_field_reg)
                FLD_YEAR0, FLD_YEAR1: year_reg   <= $signed(mac_acc[YEAR_W-1:0]);
                FLD_MONTH:            month_reg  <= $signed(mac_acc[FIELD_W-1:0]);
                FLD_DAY:              day_reg    <= $signed(mac_acc[FIELD_W-1:0]);
                FLD_HOUR:             hour_reg   <= $signed(mac_acc[FIELD_W-1:0]);
                FLD_MINUTE:           minute_reg <= $signed(mac_acc[FIELD_W-1:0]);
                FLD_SECOND:           second_reg <= $signed(mac_acc[FIELD_W-1:0]);
                default: ;
            endcase
        end
        if (state_reg == ST_CHECK && !len15_reg) begin
            year_reg <= year_reg + year_adj;
        end
        if (state_reg == ST_DIV_RUN && div_rsp.done) begin
            case (op_reg)
                DOP_YA_4:   q4_reg   <= div_rsp.quotient;
                DOP_YA_100: q100_reg <= div_rsp.quotient;
                DOP_YA_400: q400_reg <= div_rsp.quotient;
                DOP_Y_100:  z100_reg <= div_rsp.rem_zero;
                DOP_Y_400:  z400_reg <= div_rsp.rem_zero;
                default: ;
            endcase
        end
        if (state_reg == ST_SUM) begin
            csum_reg <= csum_next;
            ym_reg   <= YM_W'(year_reg) - YM_W'(EPOCH_YEAR);
        end
        if (out_load) begin
            m_tdata_reg <= bad_reg ? '0 : EPOCH_W'(mac_acc);
            m_tuser_reg <= bad_reg;
        end
    end

    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("malformed result with nonzero seconds");

    a_last_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input not stalled after last byte");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == ST_DIV_RUN)
        else $error("divider finished outside its wait state");

endmodule
